// ===== rtl/eihp_pkg.sv =====
// Package for the Ethernet/IPv4 header parser: constants, codes and record types.
// No dependencies.
`default_nettype none
package eihp_pkg;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam logic [1:0] L3_IPV4  = 2'd0;
    localparam logic [1:0] L3_ARP   = 2'd1;
    localparam logic [1:0] L3_OTHER = 2'd2;

    localparam logic [2:0] L4_TCP   = 3'd0;
    localparam logic [2:0] L4_UDP   = 3'd1;
    localparam logic [2:0] L4_ICMP  = 3'd2;
    localparam logic [2:0] L4_OTHER = 3'd3;
    localparam logic [2:0] L4_NONE  = 3'd4;

    localparam int QUEUE_DEPTH = 2;

    // Captured state of one frame handed from the front to the back.
    typedef struct packed {
        logic [16:0] n;
        logic [15:0] ether_kind;
        logic [5:0]  ihl_bytes;
        logic [15:0] total_len;
        logic [7:0]  protocol;
        logic [7:0]  ttl;
        logic [31:0] ports;
        logic [3:0]  flags;
        logic [15:0] opcode;
        logic [16:0] ip_sum;
        logic [16:0] seg_sum;
    } frame_t;

    typedef struct packed {
        logic [1:0]  l3_kind;
        logic [2:0]  l4_kind;
        logic [5:0]  ip_header_bytes;
        logic [15:0] ip_total_len;
        logic [7:0]  time_to_live;
        logic        ip_checksum_ok;
        logic        tcp_checksum_ok;
        logic [15:0] source_port;
        logic [15:0] dst_port;
        logic [3:0]  tcp_flags;
        logic [15:0] op_or_type;
        logic        frame_short;
    } record_t;

    function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] w);
        logic [17:0] t;
        logic [16:0] f;
        t = {1'b0, s} + {2'b0, w};
        f = {1'b0, t[15:0]} + {15'b0, t[17:16]};
        return f;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/eth_ipv4_header_parser_checksum.sv =====
// Ethernet/IPv4/TCP/UDP header parser with IPv4 and TCP checksum checks.
// Throughput: one byte per cycle; the input stalls only while the frame queue is full.
// The last byte's transfer writes the frame queue; the back then loads the record
// into its output register once that register is empty or its record is taken.
// Reset (aresetn low, synchronous) empties the queue and output and clears all
// frame state; state also clears after each frame's last byte.
`default_nettype none
module eth_ipv4_header_parser_checksum #(
    parameter int QUEUE_DEPTH = eihp_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_l3_kind,
    output logic [2:0]       m_l4_kind,
    output logic [5:0]       m_ip_header_bytes,
    output logic [15:0]      m_ip_total_len,
    output logic [7:0]       m_time_to_live,
    output logic             m_ip_checksum_ok,
    output logic             m_tcp_checksum_ok,
    output logic [15:0]      m_source_port,
    output logic [15:0]      m_dst_port,
    output logic [3:0]       m_tcp_flags,
    output logic [15:0]      m_op_or_type,
    output logic             m_frame_short
);
    // Front: byte-by-byte field capture and running one's-complement sums.
    logic f_valid, f_ready, b_valid, b_ready;
    eihp_pkg::frame_t f_frame, b_frame;
    eihp_pkg::record_t rec;

    eihp_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data_byte, .s_last,
        .q_valid(f_valid), .q_ready(f_ready), .q_frame(f_frame)
    );

    // Hold finished frames so the front keeps taking bytes while output stalls.
    eihp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_frame(f_frame),
        .out_valid(b_valid), .out_ready(b_ready), .out_frame(b_frame)
    );

    // Back: classify, finish the checks, register the record.
    eihp_back u_back (
        .aclk, .aresetn,
        .q_valid(b_valid), .q_ready(b_ready), .q_frame(b_frame),
        .m_valid, .m_ready, .m_rec(rec)
    );

    assign m_l3_kind = rec.l3_kind;
    assign m_l4_kind = rec.l4_kind;
    assign m_ip_header_bytes = rec.ip_header_bytes;
    assign m_ip_total_len = rec.ip_total_len;
    assign m_time_to_live = rec.time_to_live;
    assign m_ip_checksum_ok = rec.ip_checksum_ok;
    assign m_tcp_checksum_ok = rec.tcp_checksum_ok;
    assign m_source_port = rec.source_port;
    assign m_dst_port = rec.dst_port;
    assign m_tcp_flags = rec.tcp_flags;
    assign m_op_or_type = rec.op_or_type;
    assign m_frame_short = rec.frame_short;
endmodule
`default_nettype wire

// ===== rtl/eihp_front.sv =====
// Front end: takes frame bytes, captures header fields and running checksums.
// Depends on eihp_pkg.
`default_nettype none
module eihp_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_data_byte,
    input  wire logic             s_last,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output eihp_pkg::frame_t      q_frame
);
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  hi_reg, hi_next;
    logic [16:0] ip_sum_reg, ip_sum_next, seg_reg, seg_next;
    logic [15:0] ek_reg, ek_next, tl_reg, tl_next, op_reg, op_next;
    logic [5:0]  hl_reg, hl_next;
    logic [7:0]  pr_reg, pr_next, ttl_reg, ttl_next;
    logic [31:0] pt_reg, pt_next;
    logic [3:0]  fl_reg, fl_next;
    logic        take;
    logic [15:0] word, r;
    logic [16:0] l4, seg_end, p17;
    logic        odd;

    assign s_ready = q_ready;
    assign take = s_valid && s_ready;
    assign q_valid = s_valid && s_last;

    always_comb begin
        pos_next = pos_reg; hi_next = hi_reg; ip_sum_next = ip_sum_reg;
        seg_next = seg_reg; ek_next = ek_reg; tl_next = tl_reg; op_next = op_reg;
        hl_next = hl_reg; pr_next = pr_reg; ttl_next = ttl_reg; pt_next = pt_reg;
        fl_next = fl_reg;
        odd = pos_reg[0];
        word = {hi_reg, s_data_byte};
        p17 = {1'b0, pos_reg};
        l4 = 17'd14 + {11'b0, hl_reg};
        seg_end = 17'd14 + {1'b0, tl_reg};
        r = pos_reg - l4[15:0];
        if (pos_reg != 16'hFFFF) begin
            pos_next = pos_reg + 16'd1;
            if (pos_reg == 16'd13) ek_next = word;
            if (ek_reg == eihp_pkg::ETHERTYPE_IPV4 && pos_reg >= 16'd14) begin
                if (pos_reg == 16'd14) hl_next = {s_data_byte[3:0], 2'b00};
                if (pos_reg == 16'd17) tl_next = word;
                if (pos_reg == 16'd22) ttl_next = s_data_byte;
                if (pos_reg == 16'd23) pr_next = s_data_byte;
                if (odd && p17 < l4) ip_sum_next = eihp_pkg::oc_add(ip_sum_reg, word);
                if (odd && pos_reg >= 16'd26 && pos_reg <= 16'd33)
                    seg_next = eihp_pkg::oc_add(seg_reg, word);
                if (hl_reg >= 6'd20 && p17 >= l4) begin
                    if (pr_reg == eihp_pkg::PROTO_TCP || pr_reg == eihp_pkg::PROTO_UDP) begin
                        if (r == 16'd1) pt_next[31:16] = word;
                        if (r == 16'd3) pt_next[15:0] = word;
                    end
                    if (pr_reg == eihp_pkg::PROTO_TCP && r == 16'd13)
                        fl_next = {s_data_byte[4], s_data_byte[1], s_data_byte[2],
                                   s_data_byte[0]};
                    if (pr_reg == eihp_pkg::PROTO_ICMP && r == 16'd0)
                        op_next = {8'b0, s_data_byte};
                    if (p17 < seg_end) begin
                        if (odd) seg_next = eihp_pkg::oc_add(seg_reg, word);
                        else if (p17 + 17'd1 == seg_end)
                            seg_next = eihp_pkg::oc_add(seg_reg, {s_data_byte, 8'b0});
                    end
                end
            end
            if (ek_reg == eihp_pkg::ETHERTYPE_ARP && pos_reg == 16'd21) op_next = word;
            if (!odd) hi_next = s_data_byte;
        end
        q_frame.n = {1'b0, pos_next};
        q_frame.ether_kind = ek_next;
        q_frame.ihl_bytes = hl_next;
        q_frame.total_len = tl_next;
        q_frame.protocol = pr_next;
        q_frame.ttl = ttl_next;
        q_frame.ports = pt_next;
        q_frame.flags = fl_next;
        q_frame.opcode = op_next;
        q_frame.ip_sum = ip_sum_next;
        q_frame.seg_sum = seg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && s_last)) begin
            pos_reg <= '0; hi_reg <= '0; ip_sum_reg <= '0; seg_reg <= '0;
            ek_reg <= '0; tl_reg <= '0; op_reg <= '0; hl_reg <= '0;
            pr_reg <= '0; ttl_reg <= '0; pt_reg <= '0; fl_reg <= '0;
        end else if (take) begin
            pos_reg <= pos_next; hi_reg <= hi_next; ip_sum_reg <= ip_sum_next;
            seg_reg <= seg_next; ek_reg <= ek_next; tl_reg <= tl_next;
            op_reg <= op_next; hl_reg <= hl_next; pr_reg <= pr_next;
            ttl_reg <= ttl_next; pt_reg <= pt_next; fl_reg <= fl_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/eihp_queue.sv =====
// Queue of captured frames (DEPTH entries, two by default) between front and back.
// Depends on eihp_pkg.
`default_nettype none
module eihp_queue #(
    parameter int DEPTH = eihp_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire eihp_pkg::frame_t in_frame,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output eihp_pkg::frame_t      out_frame
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    eihp_pkg::frame_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != DEPTH[AW:0];
    assign out_valid = cnt_reg != '0;
    assign out_frame = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= in_frame;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop) rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/eihp_back.sv =====
// Back end: classifies a captured frame, finishes checksums, registers the record.
// Depends on eihp_pkg.
`default_nettype none
module eihp_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire eihp_pkg::frame_t q_frame,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output eihp_pkg::record_t     m_rec
);
    eihp_pkg::record_t rec_reg, rec;
    logic valid_reg;
    logic ihl_ok;
    logic [5:0] hl_eff, l4min;
    logic [16:0] s1, s2;
    logic [15:0] seglen;

    assign q_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_rec = rec_reg;

    always_comb begin
        rec = '0;
        rec.l4_kind = eihp_pkg::L4_NONE;
        ihl_ok = q_frame.ihl_bytes >= 6'd20;
        hl_eff = ihl_ok ? q_frame.ihl_bytes : 6'd20;
        l4min = '0;
        seglen = q_frame.total_len - {10'b0, q_frame.ihl_bytes};
        s1 = eihp_pkg::oc_add(q_frame.seg_sum, {8'b0, eihp_pkg::PROTO_TCP});
        s2 = eihp_pkg::oc_add(s1, seglen);
        if (q_frame.ether_kind == eihp_pkg::ETHERTYPE_IPV4) begin
            rec.l3_kind = eihp_pkg::L3_IPV4;
            case (q_frame.protocol)
                eihp_pkg::PROTO_TCP: begin rec.l4_kind = eihp_pkg::L4_TCP; l4min = 6'd20; end
                eihp_pkg::PROTO_UDP: begin rec.l4_kind = eihp_pkg::L4_UDP; l4min = 6'd8; end
                eihp_pkg::PROTO_ICMP: begin rec.l4_kind = eihp_pkg::L4_ICMP; l4min = 6'd4; end
                default: rec.l4_kind = eihp_pkg::L4_OTHER;
            endcase
            rec.ip_header_bytes = q_frame.ihl_bytes;
            rec.ip_total_len = q_frame.total_len;
            rec.time_to_live = q_frame.ttl;
            rec.frame_short = (q_frame.n < 17'd14 + {11'b0, hl_eff} + {11'b0, l4min})
                || (q_frame.n < 17'd14 + {1'b0, q_frame.total_len});
            rec.ip_checksum_ok = ihl_ok
                && (q_frame.n >= 17'd14 + {11'b0, q_frame.ihl_bytes})
                && (q_frame.ip_sum == 17'hFFFF);
            rec.tcp_checksum_ok = (rec.l4_kind == eihp_pkg::L4_TCP) && ihl_ok
                && (q_frame.total_len >= {10'b0, q_frame.ihl_bytes})
                && (q_frame.n >= 17'd14 + {1'b0, q_frame.total_len})
                && (s2 == 17'hFFFF);
            if (rec.l4_kind == eihp_pkg::L4_TCP || rec.l4_kind == eihp_pkg::L4_UDP) begin
                rec.source_port = q_frame.ports[31:16];
                rec.dst_port = q_frame.ports[15:0];
            end
            if (rec.l4_kind == eihp_pkg::L4_TCP) rec.tcp_flags = q_frame.flags;
            if (rec.l4_kind == eihp_pkg::L4_ICMP) rec.op_or_type = q_frame.opcode;
        end else if (q_frame.ether_kind == eihp_pkg::ETHERTYPE_ARP) begin
            rec.l3_kind = eihp_pkg::L3_ARP;
            rec.op_or_type = q_frame.opcode;
            rec.frame_short = q_frame.n < 17'd42;
        end else begin
            rec.l3_kind = eihp_pkg::L3_OTHER;
            rec.frame_short = q_frame.n < 17'd14;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (q_ready) valid_reg <= q_valid;
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) rec_reg <= rec;
    end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for eth_ipv4_header_parser_checksum: drives Ethernet frames byte by byte and
// checks every summary record against a predictor of its own. Depends on rtl/eihp_pkg.sv.
`timescale 1ns / 1ps
module tb;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    eihp_pkg::record_t got;

    eth_ipv4_header_parser_checksum i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_l3_kind(got.l3_kind), .m_l4_kind(got.l4_kind),
        .m_ip_header_bytes(got.ip_header_bytes), .m_ip_total_len(got.ip_total_len),
        .m_time_to_live(got.time_to_live), .m_ip_checksum_ok(got.ip_checksum_ok),
        .m_tcp_checksum_ok(got.tcp_checksum_ok), .m_source_port(got.source_port),
        .m_dst_port(got.dst_port), .m_tcp_flags(got.tcp_flags),
        .m_op_or_type(got.op_or_type), .m_frame_short(got.frame_short)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    eihp_pkg::record_t records_due[$];
    int      errors = 0;
    int      cycle_count = 0;
    int      bytes_sent = 0;
    int      frames_sent = 0;
    bit      quiet = 1'b0;      // no idling on either side when set
    bit      hold_go = 1'b0;    // toggle to ask the receiver for a long hold-off

    // Parser state mirrored by the predictor; cleared after every record.
    int unsigned pos, hi_byte, hdr_sum, seg_sum, ethertype, hdr_len, tot_len;
    int unsigned proto, ttl_v, ports_v, flags_v, opcode_v;

    function automatic int unsigned ones_add(int unsigned s, int unsigned w);
        s = s + (w & 16'hFFFF);
        s = (s & 16'hFFFF) + (s >> 16);
        return s & 17'h1FFFF;
    endfunction

    function automatic void clear_parser();
        pos = 0; hi_byte = 0; hdr_sum = 0; seg_sum = 0; ethertype = 0; hdr_len = 0;
        tot_len = 0; proto = 0; ttl_v = 0; ports_v = 0; flags_v = 0; opcode_v = 0;
    endfunction

    // Fold one byte at position p into the captured fields and running sums.
    function automatic void absorb_byte(int unsigned p, int unsigned b);
        bit          odd;
        int unsigned word, l4, seg_end, r;
        odd = p[0];
        word = ((hi_byte << 8) | b) & 16'hFFFF;
        if (p == 13) ethertype = word;
        if (ethertype == eihp_pkg::ETHERTYPE_IPV4 && p >= 14) begin
            if (p == 14) hdr_len = (b & 4'hF) * 4;
            if (p == 17) tot_len = word;
            if (p == 22) ttl_v = b;
            if (p == 23) proto = b;
            if (odd && p < 14 + hdr_len) hdr_sum = ones_add(hdr_sum, word);
            if (odd && p >= 26 && p <= 33) seg_sum = ones_add(seg_sum, word);
            if (hdr_len >= 20) begin
                l4 = 14 + hdr_len;
                seg_end = 14 + tot_len;
                if (p >= l4) begin
                    r = p - l4;
                    if (proto == eihp_pkg::PROTO_TCP || proto == eihp_pkg::PROTO_UDP) begin
                        if (r == 1) ports_v = (ports_v & 32'h0000FFFF) | (word << 16);
                        if (r == 3) ports_v = (ports_v & 32'hFFFF0000) | word;
                    end
                    if (proto == eihp_pkg::PROTO_TCP && r == 13)
                        flags_v = {28'd0, b[4], b[1], b[2], b[0]};
                    if (proto == eihp_pkg::PROTO_ICMP && r == 0) opcode_v = b;
                    if (p < seg_end) begin
                        if (odd) seg_sum = ones_add(seg_sum, word);
                        else if (p + 1 == seg_end) seg_sum = ones_add(seg_sum, b << 8);
                    end
                end
            end
        end
        if (ethertype == eihp_pkg::ETHERTYPE_ARP && p == 21) opcode_v = word;
        if (!odd) hi_byte = b;
    endfunction

    // Advance the predictor by one transfer; queue the record on the last byte.
    function automatic void predict_byte(logic [7:0] b, logic lst);
        eihp_pkg::record_t e;
        int unsigned n, hl_eff, l4min, s;
        if (pos < 16'hFFFF) begin
            absorb_byte(pos, {24'd0, b});
            pos++;
        end
        if (!lst) return;
        n = pos;
        e = '0;
        e.l4_kind = eihp_pkg::L4_NONE;
        if (ethertype == eihp_pkg::ETHERTYPE_IPV4) begin
            hl_eff = (hdr_len >= 20) ? hdr_len : 20;
            l4min = 0;
            e.l3_kind = eihp_pkg::L3_IPV4;
            if (proto == eihp_pkg::PROTO_TCP) begin
                e.l4_kind = eihp_pkg::L4_TCP; l4min = 20;
            end else if (proto == eihp_pkg::PROTO_UDP) begin
                e.l4_kind = eihp_pkg::L4_UDP; l4min = 8;
            end else if (proto == eihp_pkg::PROTO_ICMP) begin
                e.l4_kind = eihp_pkg::L4_ICMP; l4min = 4;
            end else e.l4_kind = eihp_pkg::L4_OTHER;
            e.ip_header_bytes = 6'(hdr_len);
            e.ip_total_len = 16'(tot_len);
            e.time_to_live = 8'(ttl_v);
            e.frame_short = (n < 14 + hl_eff + l4min) || (n < 14 + tot_len);
            e.ip_checksum_ok = (hdr_len >= 20) && (n >= 14 + hdr_len)
                && (hdr_sum == 16'hFFFF);
            if (e.l4_kind == eihp_pkg::L4_TCP && hdr_len >= 20 && tot_len >= hdr_len
                && n >= 14 + tot_len) begin
                s = ones_add(seg_sum, eihp_pkg::PROTO_TCP);
                s = ones_add(s, tot_len - hdr_len);
                e.tcp_checksum_ok = (s == 16'hFFFF);
            end
            if (e.l4_kind == eihp_pkg::L4_TCP || e.l4_kind == eihp_pkg::L4_UDP) begin
                e.source_port = 16'(ports_v >> 16);
                e.dst_port = 16'(ports_v);
            end
            if (e.l4_kind == eihp_pkg::L4_TCP) e.tcp_flags = 4'(flags_v);
            if (e.l4_kind == eihp_pkg::L4_ICMP) e.op_or_type = 16'(opcode_v);
        end else if (ethertype == eihp_pkg::ETHERTYPE_ARP) begin
            e.l3_kind = eihp_pkg::L3_ARP;
            e.op_or_type = 16'(opcode_v);
            e.frame_short = (n < 42);
        end else begin
            e.l3_kind = eihp_pkg::L3_OTHER;
            e.frame_short = (n < 14);
        end
        records_due.push_back(e);
        clear_parser();
    endfunction

    // Send one byte; hold valid and payload until the transfer, then maybe idle.
    task automatic send_byte(logic [7:0] b, logic lst);
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_last <= lst;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b, lst);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_frame(ref logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
        frames_sent++;
    endtask

    // One's-complement sum of cnt bytes from q[from] on, odd tail padded with zero.
    function automatic int unsigned word_sum(ref logic [7:0] q[$], input int from,
                                             input int cnt, input int unsigned init);
        int unsigned s, w;
        s = init;
        for (int i = 0; i < cnt; i += 2) begin
            w = {16'd0, q[from + i], (i + 1 < cnt) ? q[from + i + 1] : 8'h00};
            s = ones_add(s, w);
        end
        return s;
    endfunction

    // Build an Ethernet/IPv4 frame. A total length of -1 means header plus segment.
    task automatic build_ipv4(ref logic [7:0] q[$], input logic [7:0] prot, input int ihl,
                              input int seg_len, input logic [7:0] flag_byte,
                              input bit good_ip, input bit good_tcp, input int tl_force,
                              input int pad, input int cut);
        int          hlen, tl, l4;
        int unsigned c;
        hlen = (ihl < 5 ? 5 : ihl) * 4;
        tl = (tl_force < 0) ? (ihl * 4 + seg_len) : tl_force;
        q = {};
        repeat (12) q.push_back(8'($urandom));
        q.push_back(8'h08); q.push_back(8'h00);
        q.push_back({4'h4, 4'(ihl)});
        q.push_back(8'($urandom));
        q.push_back(tl[15:8]); q.push_back(tl[7:0]);
        repeat (4) q.push_back(8'($urandom));
        q.push_back(8'($urandom));           // TTL
        q.push_back(prot);
        q.push_back(8'h00); q.push_back(8'h00);
        repeat (8 + hlen - 20) q.push_back(8'($urandom));
        l4 = q.size();
        repeat (seg_len) q.push_back(8'($urandom));
        if (prot == eihp_pkg::PROTO_TCP && seg_len >= 20) begin
            q[l4 + 13] = flag_byte;
            q[l4 + 16] = 8'h00; q[l4 + 17] = 8'h00;
            c = word_sum(q, 26, 8, 0);
            c = ones_add(c, eihp_pkg::PROTO_TCP);
            c = ones_add(c, seg_len);
            c = ~word_sum(q, l4, seg_len, c) & 16'hFFFF;
            q[l4 + 16] = c[15:8]; q[l4 + 17] = c[7:0];
            if (!good_tcp) q[l4 + 19] ^= 8'h01;
        end
        c = ~word_sum(q, 14, hlen, 0) & 16'hFFFF;
        q[24] = c[15:8]; q[25] = c[7:0];
        if (!good_ip) q[25] ^= 8'h80;
        repeat (pad) q.push_back(8'($urandom));
        repeat (cut) if (q.size() > 1) void'(q.pop_back());
    endtask

    task automatic build_arp(ref logic [7:0] q[$], input int len);
        q = {};
        repeat (12) q.push_back(8'($urandom));
        q.push_back(8'h08); q.push_back(8'h06);
        repeat (len - 14) q.push_back(8'($urandom));
    endtask

    task automatic build_noise(ref logic [7:0] q[$], input int len);
        q = {};
        repeat (len) q.push_back(8'($urandom));
    endtask

    // Compare one field; report time, expected and actual on mismatch.
    function automatic void check_field(string name, int unsigned e, int unsigned a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
            errors++;
        end
    endfunction

    // Receiver: random stall bursts, plus one long hold-off on request.
    bit hold_seen = 1'b0;
    int stall_left = 0;
    always @(posedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            stall_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= (stall_left == 1);
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    // Check every record transfer against the oldest prediction.
    always @(posedge aclk) begin
        eihp_pkg::record_t e;
        if (aresetn && m_valid && m_ready) begin
            if (records_due.size() == 0) begin
                $display("%0t: record with none expected, got %h", $time, got);
                errors++;
            end else begin
                e = records_due.pop_front();
                check_field("l3_kind", e.l3_kind, got.l3_kind);
                check_field("l4_kind", e.l4_kind, got.l4_kind);
                check_field("ip_header_bytes", e.ip_header_bytes, got.ip_header_bytes);
                check_field("ip_total_len", e.ip_total_len, got.ip_total_len);
                check_field("time_to_live", e.time_to_live, got.time_to_live);
                check_field("ip_checksum_ok", e.ip_checksum_ok, got.ip_checksum_ok);
                check_field("tcp_checksum_ok", e.tcp_checksum_ok, got.tcp_checksum_ok);
                check_field("source_port", e.source_port, got.source_port);
                check_field("dst_port", e.dst_port, got.dst_port);
                check_field("tcp_flags", e.tcp_flags, got.tcp_flags);
                check_field("op_or_type", e.op_or_type, got.op_or_type);
                check_field("frame_short", e.frame_short, got.frame_short);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Directed frames: each protocol, flag mixes, malformed and truncated headers.
    task automatic test_directed();
        logic [7:0] q[$];
        build_ipv4(q, eihp_pkg::PROTO_TCP, 5, 20, 8'h12, 1, 1, -1, 0, 0); send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 5, 33, 8'hFF, 1, 1, -1, 0, 0);  // odd tail
        send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 5, 24, 8'h04, 1, 1, -1, 6, 0);  // padding
        send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 5, 20, 8'h01, 1, 0, -1, 0, 0);  // bad TCP sum
        send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 5, 20, 8'h00, 0, 1, -1, 0, 0);  // bad IP sum
        send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 15, 21, 8'h10, 1, 1, -1, 0, 0); // max IHL
        send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 5, 30, 8'h16, 1, 1, -1, 0, 5);  // cut short
        send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_UDP, 5, 12, 8'h00, 1, 1, -1, 0, 0); send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_UDP, 5, 8, 8'h00, 1, 1, -1, 0, 3); send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_ICMP, 5, 8, 8'h00, 1, 1, -1, 0, 0); send_frame(q);
        build_ipv4(q, 8'hFF, 5, 4, 8'h00, 1, 1, -1, 0, 0); send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 3, 24, 8'h12, 1, 1, -1, 0, 0);  // IHL below 5
        send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 0, 24, 8'h12, 1, 1, -1, 0, 0); send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 6, 24, 8'h12, 1, 1, 10, 0, 0);  // tl < header
        send_frame(q);
        build_ipv4(q, eihp_pkg::PROTO_TCP, 5, 20, 8'h12, 1, 1, 16'hFFFF, 0, 0);
        send_frame(q);
        build_arp(q, 42); send_frame(q);
        build_arp(q, 60); send_frame(q);
        build_arp(q, 21); send_frame(q);
        build_noise(q, 1); send_frame(q);
        build_noise(q, 13); send_frame(q);
        build_noise(q, 64); send_frame(q);
    endtask

    // Hold the receiver off while tiny frames keep coming, so the input stalls.
    task automatic test_backpressure();
        logic [7:0] q[$];
        hold_go <= ~hold_go;
        repeat (12) begin
            build_noise(q, $urandom_range(1, 3));
            send_frame(q);
        end
    endtask

    task automatic test_random();
        logic [7:0] q[$];
        int         kind, ihl, seg;
        logic [7:0] prot;
        while (bytes_sent < 1150) begin
            if (bytes_sent > 1050) quiet = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                case ($urandom_range(0, 4))
                    0, 1: prot = eihp_pkg::PROTO_TCP;
                    2: prot = eihp_pkg::PROTO_UDP;
                    3: prot = eihp_pkg::PROTO_ICMP;
                    default: prot = 8'($urandom);
                endcase
                ihl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
                seg = (prot == eihp_pkg::PROTO_TCP) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 24);
                build_ipv4(q, prot, ihl, seg, 8'($urandom), $urandom_range(0, 9) != 0,
                           $urandom_range(0, 9) != 0,
                           ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 80)) : -1,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0,
                           ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0);
            end else if (kind == 7) begin
                build_arp(q, $urandom_range(14, 50));
            end else begin
                build_noise(q, $urandom_range(1, 70));
            end
            send_frame(q);
        end
    endtask

    initial begin
        clear_parser();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random();
        s_valid <= 1'b0;
        s_last <= 1'b0;
        while (records_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
